### sv/feis_pkg.sv
// Package with the constants and the round function of the Feistel permutation.
`default_nettype none

package feis_pkg;

    localparam int ROUNDS = 8;

    localparam logic [31:0] KEY_RESET = 32'hA5B3_5705;
    localparam logic [15:0] RC_BASE   = 16'h9E37;
    localparam logic [15:0] RC_STEP   = 16'h00B7;
    localparam logic [15:0] MIX_MUL   = 16'h5BD1;

    typedef logic [15:0] t_half;
    typedef logic [31:0] t_word;

    function automatic t_half f_round_const(input int n);
        int v;
        begin
            v = int'(RC_BASE) + int'(RC_STEP) * n;
            f_round_const = v[15:0];
        end
    endfunction

    function automatic t_half f_mix(input t_half half, input t_half slice, input t_half rc);
        t_half       v;
        logic [31:0] prod;
        t_half       m;
        t_half       a;
        begin
            v     = half ^ slice ^ rc;
            prod  = v * MIX_MUL;
            m     = prod[15:0];
            a     = m + {m[8:0], m[15:9]};
            f_mix = a ^ {a[12:0], a[15:13]};
        end
    endfunction

endpackage

`default_nettype wire

### sv/feis_stage.sv
// One pipeline stage that computes one Feistel round and holds the item.
`default_nettype none

module feis_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire feis_pkg::t_word i_word,
    input  wire feis_pkg::t_half i_slice,
    input  wire feis_pkg::t_half i_rc,
    input  wire logic          i_ready_next,
    output logic               o_ready,
    output logic               o_valid,
    output feis_pkg::t_word    o_word
);
    import feis_pkg::*;

    logic  r_valid;
    t_word r_word;
    t_word n_word;

    assign o_ready = !r_valid || i_ready_next;
    assign n_word  = {i_word[15:0], i_word[31:16] ^ f_mix(i_word[15:0], i_slice, i_rc)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

### sv/feistel32_permutation.sv
// An accepted item passes through the pipeline stages, one per round, to the result.
// Throughput is one item per cycle while i_stall is low; each stage has one multiplier.
// A stalled output lets empty stages upstream keep filling, so bubbles are squeezed out.
// Synchronous active-low reset clears all valid bits and reloads the key register.
`default_nettype none

module feistel32_permutation (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire feis_pkg::t_word i_cfg_data,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire feis_pkg::t_word i_plain_word,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output feis_pkg::t_word      o_permuted_word
);
    import feis_pkg::*;

    t_word r_key;
    logic  w_valid [ROUNDS+1];
    logic  w_ready [ROUNDS+1];
    t_word w_word  [ROUNDS+1];
    logic  w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
        end else if (i_cfg_we) begin
            r_key <= i_cfg_data;
        end
    end

    assign w_valid[0]      = i_valid;
    assign w_word[0]       = i_plain_word;
    assign w_ready[ROUNDS] = !i_stall;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        feis_stage u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (w_valid[g]),
            .i_word       (w_word[g]),
            .i_slice      ((g % 2 == 1) ? r_key[31:16] : r_key[15:0]),
            .i_rc         (f_round_const(g)),
            .i_ready_next (w_ready[g+1]),
            .o_ready      (w_ready[g]),
            .o_valid      (w_valid[g+1]),
            .o_word       (w_word[g+1])
        );
    end

    always_comb begin
        w_full = 1'b1;
        for (int i = 1; i <= ROUNDS; i++) begin
            w_full = w_full & w_valid[i];
        end
    end

    assign o_stall         = !w_ready[0];
    assign o_valid         = w_valid[ROUNDS];
    assign o_permuted_word = w_word[ROUNDS];

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_full && i_stall)
        else $error("Input stalled while a stage is empty or the output moves.");

    a_free_output_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("Input stalled although the output is taken.");

    a_accept_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> w_valid[1])
        else $error("Accepted item did not reach the first stage.");
`endif

endmodule

`default_nettype wire

### tb/feistel32_permutation_tb.sv
// Self-checking testbench for the keyed 32-bit Feistel permutation with a scoreboard class.
`default_nettype none

module feistel32_permutation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import feis_pkg::*;

    localparam int ITEMS_PER_PHASE = 385;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 20;

    class permute_scoreboard;
        t_word key;
        t_word expected_words[$];
        int    errors;

        function new();
            key    = KEY_RESET;
            errors = 0;
        endfunction

        function void set_key(t_word k);
            key = k;
        endfunction

        function t_half mix_half(t_half half, int n);
            t_half slice;
            t_half rc;
            t_half v;
            slice = n[0] ? key[31:16] : key[15:0];
            rc    = RC_BASE + RC_STEP * n[15:0];
            v     = half ^ slice ^ rc;
            v     = v * MIX_MUL;
            v     = v + {v[8:0], v[15:9]};
            v     = v ^ {v[12:0], v[15:13]};
            return v;
        endfunction

        function t_word permute(t_word w);
            t_half left;
            t_half right;
            t_half next_right;
            left  = w[31:16];
            right = w[15:0];
            for (int n = 0; n < ROUNDS; n++) begin
                next_right = left ^ mix_half(right, n);
                left       = right;
                right      = next_right;
            end
            return {left, right};
        endfunction

        function void note_input(t_word w);
            expected_words.push_back(permute(w));
        endfunction

        function void check_result(t_word got);
            t_word want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected item %h, expected none", $time, got);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    $display("%0t: permuted_word mismatch, expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_cfg_we     = 1'b0;
    t_word i_cfg_data   = '0;
    logic  i_valid      = 1'b0;
    logic  o_stall;
    t_word i_plain_word = '0;
    logic  o_valid;
    logic  i_stall      = 1'b0;
    t_word o_permuted_word;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit pressure_on   = 1'b0;
    bit pressure_done = 1'b0;
    int hold_count    = 0;
    int cycle_count   = 0;

    permute_scoreboard sb = new();

    feistel32_permutation dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_plain_word    (i_plain_word),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_permuted_word (o_permuted_word)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_key(i_cfg_data);
            if (i_valid && !o_stall) sb.note_input(i_plain_word);
            if (o_valid && !i_stall) sb.check_result(o_permuted_word);
        end
    end

    always @(posedge i_clk) begin
        if (pressure_on && !pressure_done) begin
            i_stall    <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) pressure_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("feistel32_permutation regression: fail");
        $finish;
    end

    function automatic t_word random_word();
        t_word w;
        case ($urandom_range(7))
            0: w = {16'h0000, 16'($urandom)};
            1: w = {16'($urandom), 16'hFFFF};
            2: w = 32'h1 << $urandom_range(31);
            3: w = ~(32'h1 << $urandom_range(31));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_word(t_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_plain_word <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_key(t_word k);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random_phase(int idle, int stall, bit hold);
        send_idle_pct <= idle;
        stall_pct     <= stall;
        if (hold) pressure_on <= 1'b1;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) send_word(random_word());
        drain();
    endtask

    initial begin
        t_word edge_words[$] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
                                 32'h0000_0001, 32'h8000_0000, 32'h0001_0000, 32'h0000_8000,
                                 32'hAAAA_AAAA, 32'h5555_5555};
        t_word short_words[$] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (edge_words[i]) send_word(edge_words[i]);
        drain();
        write_key(32'h0000_0000);
        foreach (short_words[i]) send_word(short_words[i]);
        drain();
        write_key(32'hFFFF_FFFF);
        foreach (short_words[i]) send_word(short_words[i]);
        drain();

        write_key($urandom);
        run_random_phase(0, 0, 1'b0);
        write_key(32'hFFFF_0000);
        run_random_phase(79, 0, 1'b0);
        write_key(32'h0000_FFFF);
        run_random_phase(0, 79, 1'b0);
        write_key($urandom);
        run_random_phase(36, 36, 1'b0);
        write_key(32'h8000_0001);
        run_random_phase(0, 0, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("feistel32_permutation regression: pass");
        end else begin
            $display("feistel32_permutation regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
